/* design/mwrc_pkg.sv */
// ----------------------------------------------------------------------------
// mwrc_pkg: multi-width reflected CRC definitions
// Width codes, polynomials, masks and the bytewise reflected update.
// ----------------------------------------------------------------------------
package mwrc_pkg;

    localparam int unsigned CrcW  = 64;
    localparam int unsigned ByteW = 8;

    typedef logic [CrcW-1:0]  t_crc;
    typedef logic [ByteW-1:0] t_byte;

    // width_select register codes
    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } t_width_sel;

    localparam t_width_sel WidthReset = WIDTH_32;

    localparam t_crc CrcAllOnes = {CrcW{1'b1}};

    localparam t_crc Poly8  = 64'h0000_0000_0000_00E5;
    localparam t_crc Poly16 = 64'h0000_0000_0000_8408;
    localparam t_crc Poly32 = 64'h0000_0000_EDB8_8320;
    localparam t_crc Poly64 = 64'hC96C_5795_D787_0F42;

    localparam t_crc Mask8  = 64'h0000_0000_0000_00FF;
    localparam t_crc Mask16 = 64'h0000_0000_0000_FFFF;
    localparam t_crc Mask32 = 64'h0000_0000_FFFF_FFFF;
    localparam t_crc Mask64 = 64'hFFFF_FFFF_FFFF_FFFF;

    function automatic t_crc width_poly(input t_width_sel sel);
        t_crc poly;
        unique case (sel)
            WIDTH_8:  poly = Poly8;
            WIDTH_16: poly = Poly16;
            WIDTH_32: poly = Poly32;
            WIDTH_64: poly = Poly64;
            default:  poly = Poly32;
        endcase
        return poly;
    endfunction

    function automatic t_crc width_mask(input t_width_sel sel);
        t_crc mask;
        unique case (sel)
            WIDTH_8:  mask = Mask8;
            WIDTH_16: mask = Mask16;
            WIDTH_32: mask = Mask32;
            WIDTH_64: mask = Mask64;
            default:  mask = Mask32;
        endcase
        return mask;
    endfunction

    // Eight reflected shift steps, data bit 0 first.
    function automatic t_crc fold_byte(input t_crc crc_in, input t_byte data,
                                       input t_crc poly);
        t_crc crc;
        logic fb;
        crc = crc_in;
        for (int i = 0; i < ByteW; i++) begin
            fb  = crc[0] ^ data[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

endpackage

/* design/multi_width_reflected_crc.sv */
// ----------------------------------------------------------------------------
// multi_width_reflected_crc: streaming reflected CRC, 8/16/32/64 bit
// Running LSB-first CRC over a byte stream with a selectable width.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one message byte per transaction.
//   tdata[7:0] is the byte, tlast ends the message, tuser[0] marks the first
//   transaction of a message (load all ones first), tuser[1] says a byte is
//   present (low for an empty-message marker; tdata is then ignored).
//   Master channel m_axis_* carries one 64-bit result per message: the
//   complemented CRC masked to the selected width, upper bits zero.
//   i_cfg_wr_en / i_cfg_wr_data write width_select (0=8, 1=16, 2=32,
//   3=64 bit); change it only while the block is idle.
// Timing:
//   An input register and a result register frame the fold logic (eight
//   XOR shift steps). One transaction per cycle is accepted while no last
//   byte waits on a held result; a last transaction passes the input
//   register, then loads the result register once that register is free.
// Reset (synchronous, active low): both pipeline stages empty, CRC register
//   all ones, width_select = 32 bit.
// Stall: while the result register waits on m_axis_tready, non-last bytes
//   keep flowing into the CRC; a last byte holds in the input register, and
//   s_axis_tready drops only once that register is also held.
// ----------------------------------------------------------------------------
module multi_width_reflected_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: width_select
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // slave channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_of_message
    input  logic [1:0]  s_axis_tuser,   // [0] first_of_message, [1] byte_present
    // master channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] crc_value
);

    // configuration register
    mwrc_pkg::t_width_sel r_width;

    // input register stage
    logic               r_in_valid;
    mwrc_pkg::t_byte    r_in_data;
    logic               r_in_first;
    logic               r_in_last;
    logic               r_in_present;

    // running CRC and result register
    mwrc_pkg::t_crc     r_crc;
    logic               r_out_valid;
    mwrc_pkg::t_crc     r_out_crc;

    logic               out_free;
    logic               consume;
    logic               s_accept;
    mwrc_pkg::t_crc     mask;
    mwrc_pkg::t_crc     crc_start;
    mwrc_pkg::t_crc     n_crc;
    mwrc_pkg::t_crc     n_out_crc;

    // The result register can take a new value when empty or being drained.
    assign out_free = !r_out_valid || m_axis_tready;
    // Non-last items only touch the CRC; a last item also needs the result slot.
    assign consume  = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || consume;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Fold logic: load all ones on a first item, cut to the current width,
    // fold the byte when one is present, and form the complemented result.
    always_comb begin
        mask      = mwrc_pkg::width_mask(r_width);
        crc_start = r_in_first ? mwrc_pkg::CrcAllOnes : r_crc;
        if (r_in_present) begin
            n_crc = mwrc_pkg::fold_byte(crc_start & mask, r_in_data,
                                        mwrc_pkg::width_poly(r_width)) & mask;
        end else begin
            n_crc = crc_start;
        end
        n_out_crc = ~(n_crc & mask) & mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= mwrc_pkg::WidthReset;
        end else if (i_cfg_wr_en) begin
            r_width <= mwrc_pkg::t_width_sel'(i_cfg_wr_data);
        end
    end

    // Input register: load on accept, empty when consumed with nothing behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_data    <= s_axis_tdata;
            r_in_first   <= s_axis_tuser[0];
            r_in_last    <= s_axis_tlast;
            r_in_present <= s_axis_tuser[1];
        end
    end

    // Running CRC: advance on every consumed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mwrc_pkg::CrcAllOnes;
        end else if (consume) begin
            r_crc <= n_crc;
        end
    end

    // Result register: load on a consumed last item, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_last) begin
            r_out_crc <= n_out_crc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_crc;

endmodule

/* design/mwrc_checker.sv */
// ----------------------------------------------------------------------------
// mwrc_checker: port-level checks for multi_width_reflected_crc
// Watches the channels and configuration port over time.
// ----------------------------------------------------------------------------
module mwrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wr_en,
    input logic [1:0]  i_cfg_wr_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // shadow of width_select, seen from the configuration port
    mwrc_pkg::t_width_sel r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= mwrc_pkg::WidthReset;
        end else if (i_cfg_wr_en) begin
            r_width <= mwrc_pkg::t_width_sel'(i_cfg_wr_data);
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Result bits above the selected width are zero.
    a_out_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((r_width == mwrc_pkg::WIDTH_8)  && (m_axis_tdata[63:8]  == '0)) ||
            ((r_width == mwrc_pkg::WIDTH_16) && (m_axis_tdata[63:16] == '0)) ||
            ((r_width == mwrc_pkg::WIDTH_32) && (m_axis_tdata[63:32] == '0)) ||
            (r_width == mwrc_pkg::WIDTH_64))
        else $error("result has bits above the selected width");

    // A fresh result is checked against an accepted last transaction, which
    // reaches the result register through the input register.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a matching last transaction");

    // The input side backs up only behind a stalled result.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind multi_width_reflected_crc mwrc_checker u_mwrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
